/* rtl/core/scp_pkg.sv */
// package for the clause variable picker: widths, codes, state and control types
// no dependencies; imported by every other file of the block
`default_nettype none
package scp_pkg;
	localparam int MAX_LITERALS = 16;
	localparam int POS_W = $clog2(MAX_LITERALS + 1);
	localparam int IDX_W = $clog2(MAX_LITERALS);
	localparam int LIT_W = 21;
	localparam int SCORE_W = 18;
	localparam int AGE_W = 32;
	localparam int RND_W = 31;
	localparam int RAT_W = 10;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int JOB_W = 3;
	localparam int NUM_JOBS = 6;

	localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

	// multiple of 100: low two bits clear and the rest a multiple of 25,
	// tested with the inverse of 25 modulo 2^32 against its limit
	localparam logic [31:0] MOD25_INV = 32'hC28F5C29;
	localparam logic [31:0] MOD25_LIM = 32'h0A3D70A3;

	localparam logic [CFG_IDX_W-1:0] CFG_NOISE_NUM = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NOISE_DEN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WALK_NUM  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WALK_DEN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BUDGET    = 3'd4;

	// remainder jobs run on the shared divider
	localparam logic [JOB_W-1:0] JOB_BW   = 3'd0;
	localparam logic [JOB_W-1:0] JOB_AW   = 3'd1;
	localparam logic [JOB_W-1:0] JOB_AN   = 3'd2;
	localparam logic [JOB_W-1:0] JOB_BN   = 3'd3;
	localparam logic [JOB_W-1:0] JOB_BL   = 3'd4;
	localparam logic [JOB_W-1:0] JOB_BT   = 3'd5;

	typedef enum logic [2:0] {
		MODE_NOVELTY       = 3'd0,
		MODE_RNOVELTY      = 3'd1,
		MODE_NOVELTY_PLUS  = 3'd2,
		MODE_RNOVELTY_PLUS = 3'd3,
		MODE_BEST          = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		RES_CHOSEN  = 2'd0,
		RES_RESTART = 2'd1,
		RES_NONE    = 2'd2
	} res_status_t;

	typedef enum logic [2:0] {
		STATE_LOAD,
		STATE_DIV_GO,
		STATE_DIV_WAIT,
		STATE_DECIDE,
		STATE_SCAN,
		STATE_EMIT
	} state_t;

	typedef struct packed {
		logic             load;
		logic             div_start;
		logic [JOB_W-1:0] job;
		logic             decide;
		logic             scan_step;
		logic             emit;
	} scp_cmd_t;

	typedef struct packed {
		logic accept_last;
		logic div_done;
		logic need_pick;
		logic scan_hit;
		logic scan_end;
		logic out_busy;
	} scp_sts_t;
endpackage
`default_nettype wire

/* rtl/core/scp_if.sv */
// channel interfaces: literal input channel and pick result channel
// depends on scp_pkg for field widths
`default_nettype none
interface scp_lit_if
	import scp_pkg::*;
;
	logic                    valid;
	logic                    ready;
	logic [2:0]              mode;
	logic signed [LIT_W-1:0] literal;
	logic                    assigned;
	logic [15:0]             make_count;
	logic [15:0]             break_count;
	logic [AGE_W-1:0]        last_flip;
	logic [RND_W-1:0]        random_a;
	logic [RND_W-1:0]        random_b;
	logic                    last_literal;

	modport source(output valid, mode, literal, assigned, make_count, break_count,
		last_flip, random_a, random_b, last_literal, input ready);
	modport sink(input valid, mode, literal, assigned, make_count, break_count,
		last_flip, random_a, random_b, last_literal, output ready);
endinterface

interface scp_pick_if
	import scp_pkg::*;
;
	logic                    valid;
	logic                    ready;
	logic signed [LIT_W-1:0] chosen_literal;
	logic [1:0]              status;

	modport source(output valid, chosen_literal, status, input ready);
	modport sink(input valid, chosen_literal, status, output ready);
endinterface
`default_nettype wire

/* rtl/core/scp_divider.sv */
// restoring remainder unit, one quotient bit per cycle
// depends on scp_pkg
`default_nettype none
module scp_divider
	import scp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [RND_W-1:0] dividend,
	input  wire logic [RAT_W-1:0] divisor,
	output logic                  done,
	output logic [RAT_W-1:0]      rem
);
	localparam int CNT_W = $clog2(RND_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [RND_W-1:0] dvd_q;
	logic [RAT_W-1:0] div_q;
	logic [RAT_W-1:0] rem_q;
	logic [RAT_W:0]   trial;
	logic [RAT_W:0]   diff;

	always_comb begin
		trial = {rem_q, dvd_q[RND_W-1]};
		diff = trial - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(RND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[RND_W-2:0], 1'b0};
			rem_q <= (trial >= {1'b0, div_q}) ? diff[RAT_W-1:0] : trial[RAT_W-1:0];
		end
	end

	assign done = done_q;
	assign rem = rem_q;
endmodule
`default_nettype wire

/* rtl/core/scp_ctrl.sv */
// sequencer: load, remainder jobs, decision, rotated scan, result hand-off
// depends on scp_pkg
`default_nettype none
module scp_ctrl
	import scp_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire scp_sts_t sts,
	output scp_cmd_t      cmd
);
	state_t           state_q, state_d;
	logic [JOB_W-1:0] job_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			STATE_LOAD:     if (sts.accept_last) state_d = STATE_DIV_GO;
			STATE_DIV_GO:   state_d = STATE_DIV_WAIT;
			STATE_DIV_WAIT: begin
				if (sts.div_done)
					state_d = (job_q == JOB_W'(NUM_JOBS - 1)) ? STATE_DECIDE : STATE_DIV_GO;
			end
			STATE_DECIDE:   state_d = sts.need_pick ? STATE_SCAN : STATE_EMIT;
			STATE_SCAN:     if (sts.scan_hit || sts.scan_end) state_d = STATE_EMIT;
			STATE_EMIT:     if (!sts.out_busy) state_d = STATE_LOAD;
			default:        state_d = STATE_LOAD;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.job = job_q;
		unique case (state_q)
			STATE_LOAD:     cmd.load = 1'b1;
			STATE_DIV_GO:   cmd.div_start = 1'b1;
			STATE_DIV_WAIT: ;
			STATE_DECIDE:   cmd.decide = 1'b1;
			STATE_SCAN:     cmd.scan_step = 1'b1;
			STATE_EMIT:     cmd.emit = !sts.out_busy;
			default:        ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_LOAD;
			job_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == STATE_LOAD)
				job_q <= '0;
			else if (state_q == STATE_DIV_WAIT && sts.div_done)
				job_q <= job_q + 1'b1;
		end
	end
endmodule
`default_nettype wire

/* rtl/core/scp_datapath.sv */
// datapath: clause tracking, literal store, tie list, remainders, decision, output register
// depends on scp_pkg, scp_if and scp_divider
`default_nettype none
module scp_datapath
	import scp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	scp_lit_if.sink                    lit_ch,
	scp_pick_if.source                 pick_ch,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire scp_cmd_t              cmd,
	output scp_sts_t                   sts
);
	// configuration
	logic [RAT_W-1:0] nn_q, ndr_q, wn_q, wdr_q;
	logic [AGE_W-1:0] budget_q, rcnt_q;

	// clause state
	logic [POS_W-1:0]          pos_q, free_q, tc_q;
	logic signed [LIT_W-1:0]   lit_mem_q [MAX_LITERALS];
	logic                      asg_q [MAX_LITERALS];
	logic signed [LIT_W-1:0]   tie_q [MAX_LITERALS];
	logic signed [SCORE_W-1:0] tie_val_q, best_sc_q, sec_sc_q;
	logic signed [LIT_W-1:0]   best_lit_q, sec_lit_q, young_lit_q;
	logic [AGE_W-1:0]          best_age_q, sec_age_q, young_age_q;
	logic                      young_vld_q;
	logic [2:0]                mode_q;
	logic [RND_W-1:0]          ra_q, rb_q;
	logic [RAT_W-1:0]          rem_q [NUM_JOBS];
	logic                      a100_zero_q;

	// scan and result
	logic [IDX_W-1:0]          scan_p_q;
	logic [POS_W-1:0]          scan_left_q;
	logic signed [LIT_W-1:0]   res_lit_q;
	res_status_t               res_st_q;
	logic                      out_vld_q;
	logic signed [LIT_W-1:0]   out_lit_q;
	res_status_t               out_st_q;

	logic                      acc, take, free_in;
	logic signed [SCORE_W-1:0] score;
	logic [RAT_W-1:0]          nd, wd;
	logic [RND_W-1:0]          dvd;
	logic [RAT_W-1:0]          dvs;
	logic                      div_done;
	logic [RAT_W-1:0]          div_rem;
	logic [IDX_W-1:0]          wr_idx;
	logic [IDX_W-1:0]          tie_idx;
	logic [31:0]               ra_prod;
	mode_t                     m;

	logic                      dec_pick, dec_restart, dec_cnt_dec;
	res_status_t               dec_st;
	logic signed [LIT_W-1:0]   dec_lit;
	logic signed [SCORE_W:0]   dd;
	logic                      low_noise, young_best, walk;
	logic [RAT_W-1:0]          r_sel;
	logic signed [RAT_W+2:0]   thr;
	logic [POS_W-1:0]          scan_first;

	assign acc = cmd.load && lit_ch.valid;
	assign take = acc && (pos_q < POS_W'(MAX_LITERALS));
	assign free_in = take && !lit_ch.assigned;
	assign score = $signed({2'b00, lit_ch.make_count}) - $signed({2'b00, lit_ch.break_count});
	assign nd = (ndr_q == '0) ? RAT_W'(1) : ndr_q;
	assign wd = (wdr_q == '0) ? RAT_W'(1) : wdr_q;
	assign wr_idx = pos_q[IDX_W-1:0];
	assign tie_idx = tc_q[IDX_W-1:0];
	assign m = (mode_q > 3'(MODE_BEST)) ? MODE_BEST : mode_t'(mode_q);

	// r-novelty walk test: random_a a multiple of 100
	assign ra_prod = {3'b000, ra_q[RND_W-1:2]} * MOD25_INV;

	// operand selection for the shared divider
	always_comb begin
		dvd = rb_q;
		dvs = nd;
		case (cmd.job)
			JOB_BW:   begin dvd = rb_q; dvs = wd; end
			JOB_AW:   begin dvd = ra_q; dvs = wd; end
			JOB_AN:   begin dvd = ra_q; dvs = nd; end
			JOB_BN:   begin dvd = rb_q; dvs = nd; end
			JOB_BL:   begin dvd = rb_q; dvs = (pos_q == '0) ? RAT_W'(1) : RAT_W'(pos_q); end
			JOB_BT:   begin dvd = rb_q; dvs = (tc_q == '0) ? RAT_W'(1) : RAT_W'(tc_q); end
			default:  ;
		endcase
	end

	scp_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.done     (div_done),
		.rem      (div_rem)
	);

	// decision on the finished clause
	always_comb begin
		dec_pick = 1'b0;
		dec_restart = 1'b0;
		dec_cnt_dec = 1'b0;
		dec_st = RES_CHOSEN;
		dec_lit = '0;
		dd = {best_sc_q[SCORE_W-1], best_sc_q} - {sec_sc_q[SCORE_W-1], sec_sc_q};
		low_noise = {nn_q, 1'b0} < {1'b0, nd};
		young_best = (best_lit_q == young_lit_q) && (free_q >= POS_W'(2));
		r_sel = (m == MODE_NOVELTY || m == MODE_RNOVELTY_PLUS) ? rem_q[JOB_BN] : rem_q[JOB_AN];
		thr = $signed({({2'b00, nn_q} - {3'b000, nd[RAT_W-1:1]}), 1'b0});
		walk = (m == MODE_RNOVELTY && a100_zero_q)
			|| (m == MODE_NOVELTY_PLUS && rem_q[JOB_BW] < wn_q)
			|| (m == MODE_RNOVELTY_PLUS && rem_q[JOB_AW] < wn_q);
		if (walk) begin
			dec_pick = 1'b1;
		end else begin
			if (best_sc_q <= 0) begin
				if (rcnt_q == '0) begin
					dec_restart = 1'b1;
				end else begin
					dec_cnt_dec = 1'b1;
					dec_pick = ra_q[0];
				end
			end
			if (dec_restart) begin
				dec_st = RES_RESTART;
			end else if (dec_pick) begin
				dec_st = RES_CHOSEN;
			end else if (free_q == '0) begin
				dec_st = RES_NONE;
			end else if (m == MODE_BEST) begin
				if (tc_q == '0) dec_st = RES_NONE;
				else dec_lit = tie_q[rem_q[JOB_BT][IDX_W-1:0]];
			end else if (m == MODE_NOVELTY || m == MODE_NOVELTY_PLUS) begin
				dec_lit = (young_best && r_sel < nn_q) ? sec_lit_q : best_lit_q;
			end else begin
				dec_lit = best_lit_q;
				if (!young_best) begin
					dec_lit = best_lit_q;
				end else if (low_noise && dd > 1) begin
					dec_lit = best_lit_q;
				end else if (low_noise && dd == 1) begin
					if ({1'b0, r_sel} < {nn_q, 1'b0}) dec_lit = sec_lit_q;
				end else if (dd == 1) begin
					dec_lit = sec_lit_q;
				end else if ($signed({3'b000, rem_q[JOB_BN]}) < thr) begin
					dec_lit = sec_lit_q;
				end
			end
		end
	end

	// first scan position: offset plus one, wrapped at the stored length
	assign scan_first = rem_q[JOB_BL][POS_W-1:0] + 1'b1;

	assign sts.accept_last = acc && lit_ch.last_literal;
	assign sts.div_done = div_done;
	assign sts.need_pick = dec_pick;
	assign sts.scan_end = (scan_left_q == '0);
	assign sts.scan_hit = (scan_left_q != '0) && !asg_q[scan_p_q];
	assign sts.out_busy = out_vld_q && !pick_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nn_q <= RAT_W'(50);
			ndr_q <= RAT_W'(100);
			wn_q <= RAT_W'(1);
			wdr_q <= RAT_W'(100);
			budget_q <= AGE_W'(1000);
			rcnt_q <= AGE_W'(1000);
			pos_q <= '0;
			free_q <= '0;
			tc_q <= '0;
			tie_val_q <= SCORE_MIN;
			best_sc_q <= SCORE_MIN;
			sec_sc_q <= SCORE_MIN;
			best_lit_q <= '0;
			sec_lit_q <= '0;
			young_lit_q <= '0;
			best_age_q <= '0;
			sec_age_q <= '0;
			young_age_q <= '0;
			young_vld_q <= 1'b0;
			mode_q <= '0;
			ra_q <= '0;
			rb_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_NOISE_NUM: nn_q <= cfg_data[RAT_W-1:0];
					CFG_NOISE_DEN: ndr_q <= cfg_data[RAT_W-1:0];
					CFG_WALK_NUM:  wn_q <= cfg_data[RAT_W-1:0];
					CFG_WALK_DEN:  wdr_q <= cfg_data[RAT_W-1:0];
					CFG_BUDGET: begin
						budget_q <= cfg_data[AGE_W-1:0];
						rcnt_q <= cfg_data[AGE_W-1:0];
					end
					default: ;
				endcase
			end
			if (cmd.decide) begin
				if (dec_restart) rcnt_q <= budget_q;
				else if (dec_cnt_dec) rcnt_q <= rcnt_q - 1'b1;
			end

			if (acc && pos_q == '0) begin
				mode_q <= lit_ch.mode;
				ra_q <= lit_ch.random_a;
				rb_q <= lit_ch.random_b;
			end
			if (take) pos_q <= pos_q + 1'b1;
			if (free_in) begin
				free_q <= free_q + 1'b1;
				if (score > tie_val_q) begin
					tie_val_q <= score;
					tc_q <= POS_W'(1);
				end else if (score == tie_val_q) begin
					tc_q <= tc_q + 1'b1;
				end
				if (!young_vld_q || lit_ch.last_flip > young_age_q) begin
					young_vld_q <= 1'b1;
					young_age_q <= lit_ch.last_flip;
					young_lit_q <= lit_ch.literal;
				end
				if (score > best_sc_q || (score == best_sc_q && lit_ch.last_flip < best_age_q)) begin
					sec_lit_q <= best_lit_q;
					sec_sc_q <= best_sc_q;
					sec_age_q <= best_age_q;
					best_lit_q <= lit_ch.literal;
					best_sc_q <= score;
					best_age_q <= lit_ch.last_flip;
				end else if (score > sec_sc_q
					|| (score == sec_sc_q && lit_ch.last_flip < sec_age_q)) begin
					sec_lit_q <= lit_ch.literal;
					sec_sc_q <= score;
					sec_age_q <= lit_ch.last_flip;
				end
			end

			if (cmd.emit) begin
				out_vld_q <= 1'b1;
				pos_q <= '0;
				free_q <= '0;
				tc_q <= '0;
				tie_val_q <= SCORE_MIN;
				best_sc_q <= SCORE_MIN;
				sec_sc_q <= SCORE_MIN;
				best_lit_q <= '0;
				sec_lit_q <= '0;
				young_lit_q <= '0;
				best_age_q <= '0;
				sec_age_q <= '0;
				young_age_q <= '0;
				young_vld_q <= 1'b0;
				mode_q <= '0;
				ra_q <= '0;
				rb_q <= '0;
			end else if (pick_ch.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// stores, remainders, scan pointer and result payload
	always_ff @(posedge clk) begin
		if (take) begin
			lit_mem_q[wr_idx] <= lit_ch.literal;
			asg_q[wr_idx] <= lit_ch.assigned;
		end
		if (free_in) begin
			if (score > tie_val_q) tie_q[0] <= lit_ch.literal;
			else if (score == tie_val_q) tie_q[tie_idx] <= lit_ch.literal;
		end
		if (div_done) rem_q[cmd.job] <= div_rem;
		a100_zero_q <= (ra_q[1:0] == 2'b00) && (ra_prod <= MOD25_LIM);
		if (cmd.decide) begin
			res_lit_q <= dec_lit;
			res_st_q <= dec_st;
			scan_left_q <= pos_q;
			scan_p_q <= (scan_first == pos_q) ? '0 : scan_first[IDX_W-1:0];
		end
		if (cmd.scan_step) begin
			if (sts.scan_end) begin
				res_lit_q <= '0;
				res_st_q <= RES_NONE;
			end else if (sts.scan_hit) begin
				res_lit_q <= lit_mem_q[scan_p_q];
				res_st_q <= RES_CHOSEN;
			end else begin
				scan_left_q <= scan_left_q - 1'b1;
				scan_p_q <= (POS_W'(scan_p_q) + 1'b1 == pos_q) ? '0 : scan_p_q + 1'b1;
			end
		end
		if (cmd.emit) begin
			out_lit_q <= res_lit_q;
			out_st_q <= res_st_q;
		end
	end

	assign lit_ch.ready = cmd.load;
	assign pick_ch.valid = out_vld_q;
	assign pick_ch.chosen_literal = out_lit_q;
	assign pick_ch.status = out_st_q;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(MAX_LITERALS))
		else $error("stored length past capacity");
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		tc_q <= free_q && free_q <= pos_q)
		else $error("tie or free count exceeds stored length");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> pos_q == '0 && tc_q == '0 && out_vld_q)
		else $error("clause not cleared on result");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !cmd.load && !cmd.emit)
		else $error("divider started outside its phase");
endmodule
`default_nettype wire

/* rtl/core/sat_clause_variable_picker.sv */
// top level of the clause variable picker: sequencer plus datapath
// depends on scp_pkg, scp_if, scp_ctrl, scp_datapath
// sequence: literals load one per valid cycle while the sequencer is in its load state;
//   after the last one, six remainder jobs run on the shared divider, then the decision,
//   a rotated random pick scan when a pick is needed, and the output register
// throughput: one clause in flight; next clause loads once the result is registered
// reset: arst_n clears control, clause tracking and loads register defaults; no clearing pass
`default_nettype none
module sat_clause_variable_picker
	import scp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	scp_lit_if.sink                    lit_ch,
	scp_pick_if.source                 pick_ch,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);
	// command and status between sequencer and datapath
	scp_cmd_t cmd;
	scp_sts_t sts;

	// the sequencer walks load, remainder jobs, decide, scan and hand-off
	scp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// the datapath holds all clause state and the result register, so a
	// finished transaction can wait on the output while the next clause loads
	scp_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.lit_ch    (lit_ch),
		.pick_ch   (pick_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);
endmodule
`default_nettype wire
